@@ src/assert_macros.svh @@
// Assertion macros used by the top level of the segment intersection block.
// Each macro writes one labeled concurrent assertion on i_clk, off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sip_pkg.sv @@
// Shared constants and types for the segment intersection block.
// No dependencies; imported by every sip_* module and the top level.
package sip_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    // Q2.30 parameter format
    localparam int QUO_FRAC        = 30;
    localparam int QUO_BITS        = QUO_FRAC + 2;
    localparam int DTOL_WIDTH      = 32;
    localparam int PTOL_WIDTH      = 31;
    localparam int CFG_IDX_WIDTH   = 1;
    localparam int CFG_DATA_WIDTH  = 32;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_PAR_TOL = 1'b0,
        REG_PRM_TOL = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [DTOL_WIDTH-1:0] par_tol;
        logic [PTOL_WIDTH-1:0] prm_tol;
    } t_cfg;

endpackage

@@ src/segment_intersection_point.sv @@
// Top level of the segment intersection block: stream ports, configuration
// registers, front end, divider and back end. Uses sip_pkg and assert_macros.svh.
//
// Usage:
//   Input words on the s_axis channel carry two segments AB and CD as signed
//   fixed-point coordinates (A, B, C, D; x then y). Output words on the
//   m_axis channel carry the intersection point; tuser is the hit flag and the
//   point is zero on a miss (parallel segments or parameters out of range).
//   The pipeline has 5 front-end stages, 32 divider stages (one quotient
//   bit each) and 5 back-end stages ending in the output register.
//   Throughput is one word per cycle; the whole pipeline moves on one enable.
//   When the receiver stalls with a word waiting, every stage holds and
//   o_s_axis_tready drops; nothing is lost or repeated. Reset clears all valid
//   bits and both tolerance registers to zero. Tolerances are written through
//   i_cfg_* while the pipeline is empty, a rule for the user that the block does
//   not enforce. Index 0 is the parallel tolerance, index 1 the parameter slack.
`include "assert_macros.svh"

module segment_intersection_point import sip_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int OUT_TW = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
    // seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y
    input  logic [8*COORD_WIDTH-1:0]  i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // point_x, point_y, zero fill
    output logic [OUT_TW-1:0]         o_m_axis_tdata,
    // hit
    output logic                      o_m_axis_tuser,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_wr_data
);

    localparam int NW  = 2 * (COORD_WIDTH + 1) + 1;
    localparam int SBW = 4 * COORD_WIDTH + 7;

    t_cfg r_cfg;
    logic w_adv;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_PAR_TOL: r_cfg.par_tol <= i_cfg_wr_data[DTOL_WIDTH-1:0];
                REG_PRM_TOL: r_cfg.prm_tol <= i_cfg_wr_data[PTOL_WIDTH-1:0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    // Advance everything unless a finished word is waiting on a stalled receiver
    assign w_adv           = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    logic               w_f_vld, w_d_vld;
    logic [NW-1:0]      w_den, w_na, w_nb;
    logic [SBW-1:0]     w_f_sb, w_d_sb;
    logic [QUO_BITS-1:0] w_qa, w_qb;
    logic [COORD_WIDTH-1:0] w_px, w_py;

    sip_cross #(.W(COORD_WIDTH)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_s_axis_tvalid),
        .i_tdata (i_s_axis_tdata),
        .i_cfg   (r_cfg),
        .o_valid (w_f_vld),
        .o_den   (w_den),
        .o_num_a (w_na),
        .o_num_b (w_nb),
        .o_sb    (w_f_sb)
    );

    sip_divider #(.NW(NW), .SBW(SBW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_f_vld),
        .i_den   (w_den),
        .i_num_a (w_na),
        .i_num_b (w_nb),
        .i_sb    (w_f_sb),
        .o_valid (w_d_vld),
        .o_qa    (w_qa),
        .o_qb    (w_qb),
        .o_sb    (w_d_sb)
    );

    sip_lerp #(.W(COORD_WIDTH)) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_d_vld),
        .i_qa    (w_qa),
        .i_qb    (w_qb),
        .i_sb    (w_d_sb),
        .i_cfg   (r_cfg),
        .o_valid (o_m_axis_tvalid),
        .o_hit   (o_m_axis_tuser),
        .o_px    (w_px),
        .o_py    (w_py)
    );

    assign o_m_axis_tdata = OUT_TW'({w_py, w_px});

    // A miss carries a zero point
    `SIP_ASSERT_NOW(a_miss_zero, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata == '0, "miss with nonzero point")
    // A stall freezes the pipeline between front end and divider
    `SIP_ASSERT_NEXT(a_stall_hold, !o_s_axis_tready, $stable(w_f_vld) && $stable(w_d_vld), "pipeline moved during stall")
    // A stalled output word keeps its hit flag while the pipeline behind it holds
    `SIP_ASSERT_NEXT(a_stall_hit, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tuser) && $stable(w_d_sb), "output changed during stall")

endmodule

@@ src/sip_cross.sv @@
// Front end: coordinate differences, cross products, denominator and numerators,
// magnitudes and the parallel / far-out tests. Five register stages. Uses sip_pkg.
module sip_cross import sip_pkg::*; #(
    parameter int W = COORD_WIDTH_DEF,
    localparam int DFW = W + 1,
    localparam int PW  = 2 * DFW,
    localparam int NW  = PW + 1,
    localparam int SBW = 4 * W + 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  logic [8*W-1:0]  i_tdata,
    input  t_cfg            i_cfg,
    output logic            o_valid,
    output logic [NW-1:0]   o_den,
    output logic [NW-1:0]   o_num_a,
    output logic [NW-1:0]   o_num_b,
    // {par, neg_a, neg_b, sat_a, sat_b, ax, ay, x21, y21}
    output logic [SBW-1:0]  o_sb
);

    logic signed [W-1:0] w_ax, w_ay, w_bx, w_by, w_cx, w_cy, w_dx, w_dy;

    assign w_ax = i_tdata[0*W +: W];
    assign w_ay = i_tdata[1*W +: W];
    assign w_bx = i_tdata[2*W +: W];
    assign w_by = i_tdata[3*W +: W];
    assign w_cx = i_tdata[4*W +: W];
    assign w_cy = i_tdata[5*W +: W];
    assign w_dx = i_tdata[6*W +: W];
    assign w_dy = i_tdata[7*W +: W];

    logic [4:0] r_vld;

    logic signed [W-1:0]   r1_ax, r1_ay, r2_ax, r2_ay, r3_ax, r3_ay, r4_ax, r4_ay;
    logic signed [DFW-1:0] r1_x43, r1_y43, r1_x21, r1_y21, r1_x13, r1_y13;
    logic signed [DFW-1:0] r2_x21, r2_y21, r3_x21, r3_y21, r4_x21, r4_y21;
    logic signed [PW-1:0]  r2_pd1, r2_pd2, r2_pa1, r2_pa2, r2_pb1, r2_pb2;
    logic signed [NW-1:0]  r3_den, r3_na, r3_nb;
    logic [NW-1:0]         r4_dmag, r4_amag, r4_bmag;
    logic                  r4_neg_a, r4_neg_b;
    logic [NW-1:0]         r5_d, r5_a, r5_b;
    logic [SBW-1:0]        r5_sb;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // Stage 1: differences
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_ax  <= w_ax;
            r1_ay  <= w_ay;
            r1_x43 <= DFW'(w_dx) - DFW'(w_cx);
            r1_y43 <= DFW'(w_dy) - DFW'(w_cy);
            r1_x21 <= DFW'(w_bx) - DFW'(w_ax);
            r1_y21 <= DFW'(w_by) - DFW'(w_ay);
            r1_x13 <= DFW'(w_ax) - DFW'(w_cx);
            r1_y13 <= DFW'(w_ay) - DFW'(w_cy);
        end
    end

    // Stage 2: cross products
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_x21 <= r1_x21;
            r2_y21 <= r1_y21;
            r2_pd1 <= r1_y43 * r1_x21;
            r2_pd2 <= r1_x43 * r1_y21;
            r2_pa1 <= r1_x43 * r1_y13;
            r2_pa2 <= r1_y43 * r1_x13;
            r2_pb1 <= r1_x21 * r1_y13;
            r2_pb2 <= r1_y21 * r1_x13;
        end
    end

    // Stage 3: denominator and numerators
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_x21 <= r2_x21;
            r3_y21 <= r2_y21;
            r3_den <= NW'(r2_pd1) - NW'(r2_pd2);
            r3_na  <= NW'(r2_pa1) - NW'(r2_pa2);
            r3_nb  <= NW'(r2_pb1) - NW'(r2_pb2);
        end
    end

    // Stage 4: magnitudes and quotient signs
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_ax    <= r3_ax;
            r4_ay    <= r3_ay;
            r4_x21   <= r3_x21;
            r4_y21   <= r3_y21;
            r4_dmag  <= r3_den[NW-1] ? NW'(-r3_den) : NW'(r3_den);
            r4_amag  <= r3_na[NW-1]  ? NW'(-r3_na)  : NW'(r3_na);
            r4_bmag  <= r3_nb[NW-1]  ? NW'(-r3_nb)  : NW'(r3_nb);
            r4_neg_a <= r3_na[NW-1] ^ r3_den[NW-1];
            r4_neg_b <= r3_nb[NW-1] ^ r3_den[NW-1];
        end
    end

    // Stage 5: parallel test and quotient overflow (|num| >= 4|den|)
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_d  <= r4_dmag;
            r5_a  <= r4_amag;
            r5_b  <= r4_bmag;
            r5_sb <= {(r4_dmag <= NW'(i_cfg.par_tol)),
                      r4_neg_a, r4_neg_b,
                      ({2'b00, r4_amag} >= {r4_dmag, 2'b00}),
                      ({2'b00, r4_bmag} >= {r4_dmag, 2'b00}),
                      r4_ax, r4_ay, r4_x21, r4_y21};
        end
    end

    assign o_valid = r_vld[4];
    assign o_den   = r5_d;
    assign o_num_a = r5_a;
    assign o_num_b = r5_b;
    assign o_sb    = r5_sb;

endmodule

@@ src/sip_divider.sv @@
// Two-lane restoring divider, one quotient bit per register stage, shared divisor.
// Gives floor(num * 2^30 / den) for num < 4*den. Uses sip_pkg.
module sip_divider import sip_pkg::*; #(
    parameter int NW  = 67,
    parameter int SBW = 135
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic [NW-1:0]       i_den,
    input  logic [NW-1:0]       i_num_a,
    input  logic [NW-1:0]       i_num_b,
    input  logic [SBW-1:0]      i_sb,
    output logic                o_valid,
    output logic [QUO_BITS-1:0] o_qa,
    output logic [QUO_BITS-1:0] o_qb,
    output logic [SBW-1:0]      o_sb
);

    logic [NW-1:0]       w_d  [QUO_BITS+1];
    logic [NW-1:0]       w_ra [QUO_BITS+1];
    logic [NW-1:0]       w_rb [QUO_BITS+1];
    logic [QUO_BITS-1:0] w_qa [QUO_BITS+1];
    logic [QUO_BITS-1:0] w_qb [QUO_BITS+1];
    logic [SBW-1:0]      w_sb [QUO_BITS+1];
    logic                w_vld[QUO_BITS+1];

    // Load: the top of num*2^30 is num/4; the low dividend bits ride in the quotient word
    assign w_d[0]   = i_den;
    assign w_ra[0]  = i_num_a >> 2;
    assign w_rb[0]  = i_num_b >> 2;
    assign w_qa[0]  = {i_num_a[1:0], {QUO_FRAC{1'b0}}};
    assign w_qb[0]  = {i_num_b[1:0], {QUO_FRAC{1'b0}}};
    assign w_sb[0]  = i_sb;
    assign w_vld[0] = i_valid;

    for (genvar g = 0; g < QUO_BITS; g++) begin : g_step
        logic [NW-1:0]       w_ta, w_tb;
        logic                w_ga, w_gb;
        logic [NW-1:0]       r_d, r_ra, r_rb;
        logic [QUO_BITS-1:0] r_qa, r_qb;
        logic [SBW-1:0]      r_sb;
        logic                r_vld;

        // Shift in the next dividend bit, subtract if it fits
        assign w_ta = {w_ra[g][NW-2:0], w_qa[g][QUO_BITS-1]};
        assign w_tb = {w_rb[g][NW-2:0], w_qb[g][QUO_BITS-1]};
        assign w_ga = (w_ta >= w_d[g]);
        assign w_gb = (w_tb >= w_d[g]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_adv) begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_d  <= w_d[g];
                r_ra <= w_ga ? (w_ta - w_d[g]) : w_ta;
                r_rb <= w_gb ? (w_tb - w_d[g]) : w_tb;
                r_qa <= {w_qa[g][QUO_BITS-2:0], w_ga};
                r_qb <= {w_qb[g][QUO_BITS-2:0], w_gb};
                r_sb <= w_sb[g];
            end
        end

        assign w_d[g+1]   = r_d;
        assign w_ra[g+1]  = r_ra;
        assign w_rb[g+1]  = r_rb;
        assign w_qa[g+1]  = r_qa;
        assign w_qb[g+1]  = r_qb;
        assign w_sb[g+1]  = r_sb;
        assign w_vld[g+1] = r_vld;
    end

    assign o_valid = w_vld[QUO_BITS];
    assign o_qa    = w_qa[QUO_BITS];
    assign o_qb    = w_qb[QUO_BITS];
    assign o_sb    = w_sb[QUO_BITS];

endmodule

@@ src/sip_lerp.sv @@
// Back end: signed parameters, range test, A + ua*(B-A) with truncation and
// saturation. Five register stages, the last one is the output register. Uses sip_pkg.
module sip_lerp import sip_pkg::*; #(
    parameter int W = COORD_WIDTH_DEF,
    localparam int DFW = W + 1,
    localparam int SBW = 4 * W + 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic [QUO_BITS-1:0] i_qa,
    input  logic [QUO_BITS-1:0] i_qb,
    input  logic [SBW-1:0]      i_sb,
    input  t_cfg                i_cfg,
    output logic                o_valid,
    output logic                o_hit,
    output logic [W-1:0]        o_px,
    output logic [W-1:0]        o_py
);

    localparam int UW  = QUO_BITS + 2;
    localparam int LPW = UW + DFW;
    localparam int TW  = LPW - QUO_FRAC;
    localparam int SW  = TW + 1;

    logic                  w_par, w_neg_a, w_neg_b, w_sat_a, w_sat_b;
    logic signed [W-1:0]   w_ax, w_ay;
    logic signed [DFW-1:0] w_x21, w_y21;
    logic [QUO_BITS:0]     w_qa, w_qb;

    assign {w_par, w_neg_a, w_neg_b, w_sat_a, w_sat_b, w_ax, w_ay, w_x21, w_y21} = i_sb;
    assign w_qa = w_sat_a ? {1'b1, {QUO_BITS{1'b0}}} : {1'b0, i_qa};
    assign w_qb = w_sat_b ? {1'b1, {QUO_BITS{1'b0}}} : {1'b0, i_qb};

    logic [4:0] r_vld;

    logic signed [UW-1:0]  r1_ua, r1_ub, r2_ua;
    logic                  r1_par, r2_hit, r3_hit, r4_hit;
    logic signed [W-1:0]   r1_ax, r1_ay, r2_ax, r2_ay, r3_ax, r3_ay, r4_ax, r4_ay;
    logic signed [DFW-1:0] r1_x21, r1_y21, r2_x21, r2_y21;
    logic signed [LPW-1:0] r3_prx, r3_pry;
    logic signed [TW-1:0]  r4_tx, r4_ty;
    logic                  r5_hit;
    logic [W-1:0]          r5_px, r5_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // Stage 1: apply quotient signs
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_ua  <= w_neg_a ? -$signed({1'b0, w_qa}) : $signed({1'b0, w_qa});
            r1_ub  <= w_neg_b ? -$signed({1'b0, w_qb}) : $signed({1'b0, w_qb});
            r1_par <= w_par;
            r1_ax  <= w_ax;
            r1_ay  <= w_ay;
            r1_x21 <= w_x21;
            r1_y21 <= w_y21;
        end
    end

    // Stage 2: both parameters within [-tol, 1 + tol]
    logic signed [UW-1:0] w_lo, w_hi;
    logic                 w_in_a, w_in_b;

    assign w_lo   = -$signed(UW'(i_cfg.prm_tol));
    assign w_hi   = $signed(UW'({1'b1, {QUO_FRAC{1'b0}}})) + $signed(UW'(i_cfg.prm_tol));
    assign w_in_a = (r1_ua >= w_lo) && (r1_ua <= w_hi);
    assign w_in_b = (r1_ub >= w_lo) && (r1_ub <= w_hi);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_hit <= !r1_par && w_in_a && w_in_b;
            r2_ua  <= r1_ua;
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_x21 <= r1_x21;
            r2_y21 <= r1_y21;
        end
    end

    // Stage 3: ua * (B - A)
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_hit <= r2_hit;
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_prx <= r2_ua * r2_x21;
            r3_pry <= r2_ua * r2_y21;
        end
    end

    // Stage 4: drop 30 fraction bits, rounding toward zero
    logic signed [LPW-1:0] w_bx, w_by;

    assign w_bx = r3_prx + $signed({{(LPW-QUO_FRAC){1'b0}}, {QUO_FRAC{r3_prx[LPW-1]}}});
    assign w_by = r3_pry + $signed({{(LPW-QUO_FRAC){1'b0}}, {QUO_FRAC{r3_pry[LPW-1]}}});

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_hit <= r3_hit;
            r4_ax  <= r3_ax;
            r4_ay  <= r3_ay;
            r4_tx  <= w_bx[LPW-1:QUO_FRAC];
            r4_ty  <= w_by[LPW-1:QUO_FRAC];
        end
    end

    // Stage 5: add the base point, saturate, zero on a miss
    logic signed [SW-1:0] w_sx, w_sy;
    logic [W-1:0]         w_cx, w_cy;

    assign w_sx = SW'(r4_ax) + SW'(r4_tx);
    assign w_sy = SW'(r4_ay) + SW'(r4_ty);

    always_comb begin
        if (w_sx[SW-1:W-1] == '0 || w_sx[SW-1:W-1] == '1) begin
            w_cx = w_sx[W-1:0];
        end else begin
            w_cx = {w_sx[SW-1], {(W-1){~w_sx[SW-1]}}};
        end
        if (w_sy[SW-1:W-1] == '0 || w_sy[SW-1:W-1] == '1) begin
            w_cy = w_sy[W-1:0];
        end else begin
            w_cy = {w_sy[SW-1], {(W-1){~w_sy[SW-1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_hit <= r4_hit;
            r5_px  <= r4_hit ? w_cx : '0;
            r5_py  <= r4_hit ? w_cy : '0;
        end
    end

    assign o_valid = r_vld[4];
    assign o_hit   = r5_hit;
    assign o_px    = r5_px;
    assign o_py    = r5_py;

endmodule
